// ===== rtl/core/cpf_pkg.sv =====
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared types, constants and the byte-wise crc-16 step of the packet framer.
// ----------------------------------------------------------------------------
package cpf_pkg;

   localparam logic [15:0] CRC_INIT     = 16'hd77f;
   localparam logic [15:0] CRC_POLY     = 16'h8005;
   localparam int          BUFFER_BYTES = 2048;
   localparam int          COUNT_W      = 12;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [7:0]  DTC_RESET    = 8'd7;
   localparam int          HDR_BYTES    = 4;

   // command queue between front and back, depth a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] packet_type;
      logic [7:0] data_byte;
      logic       byte_present;
      logic       first_item;
      logic       last_item;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       oversize;
      logic       run_end;
   } rsp_type;

   typedef struct packed {
      logic       hdr;
      logic [7:0] ptype;
      logic [7:0] seq;
      logic       present;
      logic [7:0] dbyte;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/cpf_front.sv =====
// ----------------------------------------------------------------------------
// cpf_front
// Accepts items, tracks packet state and sequence, queues byte-run commands.
// ----------------------------------------------------------------------------
module cpf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  cpf_pkg::req_type     req_data,
   input  logic                 csr_valid,
   input  logic [7:0]           csr_wdata,
   input  cpf_pkg::q_status_type q_status,
   output logic                 q_push,
   output cpf_pkg::cmd_type     q_cmd
);

   logic       open_ff, open_in;
   logic [7:0] seq_ff, seq_in;
   logic [7:0] dtc_ff, dtc_in;
   logic       accept;
   logic       is_data;
   logic       produce;

   always_comb begin
      accept  = req_push && !q_status.full;
      is_data = req_data.first_item && (req_data.packet_type == dtc_ff);
      produce = req_data.first_item ||
                (open_ff && (req_data.byte_present || req_data.last_item));

      q_cmd.hdr     = req_data.first_item;
      q_cmd.ptype   = req_data.packet_type;
      q_cmd.seq     = is_data ? seq_ff : 8'd0;
      q_cmd.present = req_data.byte_present;
      q_cmd.dbyte   = req_data.data_byte;
      q_cmd.last    = req_data.last_item;
      q_push        = accept && produce;

      open_in = open_ff;
      seq_in  = seq_ff;
      dtc_in  = csr_valid ? csr_wdata : dtc_ff;
      if (accept) begin
         if (req_data.first_item) begin
            open_in = 1'b1;
         end
         if (is_data) begin
            seq_in = seq_ff + 8'd1;
         end
         if ((req_data.first_item || open_ff) && req_data.last_item) begin
            open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         seq_ff  <= '0;
         dtc_ff  <= cpf_pkg::DTC_RESET;
      end else begin
         open_ff <= open_in;
         seq_ff  <= seq_in;
         dtc_ff  <= dtc_in;
      end
   end

endmodule

// ===== rtl/core/cpf_queue.sv =====
// ----------------------------------------------------------------------------
// cpf_queue
// Short command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module cpf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cpf_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output cpf_pkg::cmd_type      head,
   output cpf_pkg::q_status_type status
);

   cpf_pkg::cmd_type                  mem_ff [cpf_pkg::QUEUE_DEPTH];
   logic [cpf_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [cpf_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [cpf_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              do_push, do_pop;

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == cpf_pkg::QCNT_W'(cpf_pkg::QUEUE_DEPTH));
      do_push   = push && !status.full;
      do_pop    = pop && !status.empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      head = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/cpf_back.sv =====
// ----------------------------------------------------------------------------
// cpf_back
// Expands queued commands into wire bytes, runs the crc and the payload count.
// ----------------------------------------------------------------------------
module cpf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  cpf_pkg::q_status_type q_status,
   input  cpf_pkg::cmd_type      q_head,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output cpf_pkg::rsp_type      rsp_data
);

   typedef enum logic [4:0] {
      PH_TYPE = 5'b00001,
      PH_SEQ  = 5'b00010,
      PH_DATA = 5'b00100,
      PH_CRCH = 5'b01000,
      PH_CRCL = 5'b10000
   } phase_type;

   phase_type                     phase_ff, phase_in, cur;
   logic                          busy_ff, busy_in;
   logic [15:0]                   crc_ff, crc_in;
   logic [cpf_pkg::COUNT_W-1:0]   cnt_ff, cnt_in;
   logic                          out_valid_ff, out_valid_in;
   cpf_pkg::rsp_type              out_ff, out_in;
   logic                          advance, fire, done;
   logic                          over;
   phase_type                     next;

   always_comb begin
      advance = !out_valid_ff || rsp_pop;
      fire    = !q_status.empty && advance;
      over    = ((cpf_pkg::COUNT_W + 1)'(cnt_ff) + (cpf_pkg::COUNT_W + 1)'(cpf_pkg::HDR_BYTES))
                > (cpf_pkg::COUNT_W + 1)'(cpf_pkg::BUFFER_BYTES);

      if (busy_ff) begin
         cur = phase_ff;
      end else if (q_head.hdr) begin
         cur = PH_TYPE;
      end else if (q_head.present) begin
         cur = PH_DATA;
      end else begin
         cur = PH_CRCH;
      end

      crc_in = crc_ff;
      cnt_in = cnt_ff;
      next   = PH_CRCH;
      done   = 1'b1;
      out_in = '0;
      unique case (cur)
         PH_TYPE: begin
            out_in.out_byte = q_head.ptype;
            crc_in = cpf_pkg::crc_feed(cpf_pkg::CRC_INIT, q_head.ptype);
            cnt_in = '0;
            next   = PH_SEQ;
            done   = 1'b0;
         end
         PH_SEQ: begin
            out_in.out_byte = q_head.seq;
            crc_in = cpf_pkg::crc_feed(crc_ff, q_head.seq);
            next   = q_head.present ? PH_DATA : PH_CRCH;
            done   = !q_head.present && !q_head.last;
         end
         PH_DATA: begin
            out_in.out_byte = q_head.dbyte;
            crc_in = cpf_pkg::crc_feed(crc_ff, q_head.dbyte);
            if (cnt_ff != cpf_pkg::COUNT_MAX) begin
               cnt_in = cnt_ff + 1'b1;
            end
            next   = PH_CRCH;
            done   = !q_head.last;
         end
         PH_CRCH: begin
            out_in.out_byte = crc_ff[15:8];
            next   = PH_CRCL;
            done   = 1'b0;
         end
         PH_CRCL: begin
            out_in.out_byte  = crc_ff[7:0];
            out_in.frame_end = 1'b1;
            out_in.oversize  = over;
         end
         default: begin
            done = 1'b1;
         end
      endcase
      out_in.run_end = done;

      q_pop        = fire && done;
      busy_in      = busy_ff;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (fire) begin
         busy_in      = !done;
         phase_in     = next;
         out_valid_in = 1'b1;
      end
      rsp_empty = !out_valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         crc_ff <= crc_in;
         cnt_ff <= cnt_in;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_TYPE;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_busy_has_cmd: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !q_status.empty)
      else $error("back busy with no queued command");
   a_end_is_run_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.frame_end) |-> out_ff.run_end)
      else $error("frame end without run end");
   a_over_on_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.oversize) |-> out_ff.frame_end)
      else $error("oversize flag off the frame end byte");
   a_crcl_after_crch: assert property (@(posedge clock) disable iff (reset)
      (fire && cur == PH_CRCH) |=> (busy_ff && phase_ff == PH_CRCL))
      else $error("low crc byte does not follow high crc byte");
`endif

endmodule

// ===== rtl/core/crc16_packet_framer_core.sv =====
// ----------------------------------------------------------------------------
// crc16_packet_framer_core
// Packet framer: type, sequence, payload and big-endian crc-16 (0x8005).
// ----------------------------------------------------------------------------
// usage:
//   req side is a queue input: an item transfers when req_push is high and
//   req_full is low. each item carries a type, one optional payload byte and
//   first/last marks. rsp side is a queue output: the oldest byte waits on
//   rsp_data while rsp_empty is low and transfers when rsp_pop is high.
//   csr_valid/csr_ready write the data type code; csr_ready is always high.
// byte flow:
//   items reach rsp through the command queue and then the output register.
//   while that register is empty or popped the back end emits one byte per
//   cycle: middle payload items run one per cycle, a first item adds type and
//   sequence bytes, a last the two crc bytes, which a four-deep queue absorbs.
// reset:
//   synchronous; empties the queue and the output register, closes the open
//   packet, clears the sequence count and sets the data type code to 7.
// stall:
//   while rsp_pop stays low the output byte holds, the back end stops, and
//   req_full rises once the command queue fills.
// ----------------------------------------------------------------------------
module crc16_packet_framer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  cpf_pkg::req_type  req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output cpf_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_wdata
);

   cpf_pkg::q_status_type q_status;
   cpf_pkg::cmd_type      q_cmd;
   cpf_pkg::cmd_type      q_head;
   logic                  q_push;
   logic                  q_pop;

   assign req_full  = q_status.full;
   assign csr_ready = 1'b1;

   cpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   cpf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   cpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
